### rtl/dews_pkg.sv
// ---------------------------------------------------------------------------
// dews_pkg
// Shared types, kind codes and helpers for the determinant excitation
// pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dews_pkg;

	localparam int unsigned NORB = 64;
	localparam int unsigned IDXW = 6;
	localparam int unsigned KINDW = 3;

	localparam logic [KINDW-1:0] KIND_SINGLE_UP   = 3'd0;
	localparam logic [KINDW-1:0] KIND_SINGLE_DOWN = 3'd1;
	localparam logic [KINDW-1:0] KIND_DOUBLE_UU   = 3'd2;
	localparam logic [KINDW-1:0] KIND_DOUBLE_UD   = 3'd3;
	localparam logic [KINDW-1:0] KIND_DOUBLE_DD   = 3'd4;

	typedef logic [NORB-1:0] occ_t;
	typedef logic [IDXW-1:0] idx_t;

	// decoded item after stage 1
	typedef struct packed {
		occ_t up;
		occ_t dn;
		logic kind_ok;
		logic is_double;
		logic is_ud;
		logic on_down;
		logic distinct;
		occ_t ms1;
		occ_t md1;
		occ_t ms2;
		occ_t md2;
		occ_t bm1;
		occ_t bm2;
	} dec_t;

	// moved strings and parity operands after stage 2
	typedef struct packed {
		occ_t nu;
		occ_t nd;
		logic ok;
		occ_t v1;
		occ_t v2;
	} mov_t;

	function automatic occ_t onehot(input idx_t p);
		occ_t r;
		r = '0;
		r[p] = 1'b1;
		return r;
	endfunction

	// bits strictly between positions p and q
	function automatic occ_t between_mask(input idx_t p, input idx_t q);
		occ_t r;
		idx_t lo;
		idx_t hi;
		lo = (p < q) ? p : q;
		hi = (p < q) ? q : p;
		for (int k = 0; k < NORB; k++) begin
			r[k] = (idx_t'(k) > lo) && (idx_t'(k) < hi);
		end
		return r;
	endfunction

endpackage

### rtl/dews_decode.sv
// ---------------------------------------------------------------------------
// dews_decode
// Stage 1: kind decode, one-hot orbital masks and between-masks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dews_decode (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_i,
	output logic                       ready_o,
	input  dews_pkg::occ_t             up_string,
	input  dews_pkg::occ_t             down_string,
	input  logic [dews_pkg::KINDW-1:0] kind,
	input  dews_pkg::idx_t             src_first,
	input  dews_pkg::idx_t             second_index,
	input  dews_pkg::idx_t             third_index,
	input  dews_pkg::idx_t             fourth_index,
	output logic                       valid_s1,
	input  logic                       ready_i,
	output dews_pkg::dec_t             data_s1
);

	dews_pkg::dec_t nxt;
	dews_pkg::idx_t dst1;

	always_comb begin
		nxt = '0;
		unique case (kind)
			dews_pkg::KIND_SINGLE_UP: begin
				nxt.kind_ok = 1'b1;
			end
			dews_pkg::KIND_SINGLE_DOWN: begin
				nxt.kind_ok = 1'b1;
				nxt.on_down = 1'b1;
			end
			dews_pkg::KIND_DOUBLE_UU: begin
				nxt.kind_ok   = 1'b1;
				nxt.is_double = 1'b1;
			end
			dews_pkg::KIND_DOUBLE_UD: begin
				nxt.kind_ok   = 1'b1;
				nxt.is_double = 1'b1;
				nxt.is_ud     = 1'b1;
			end
			dews_pkg::KIND_DOUBLE_DD: begin
				nxt.kind_ok   = 1'b1;
				nxt.is_double = 1'b1;
				nxt.on_down   = 1'b1;
			end
			default: begin
				nxt.kind_ok = 1'b0;
			end
		endcase
		// singles target second_index, doubles third_index
		dst1         = nxt.is_double ? third_index : second_index;
		nxt.up       = up_string;
		nxt.dn       = down_string;
		nxt.distinct = (src_first != second_index) && (third_index != fourth_index);
		nxt.ms1      = dews_pkg::onehot(src_first);
		nxt.md1      = dews_pkg::onehot(dst1);
		nxt.ms2      = dews_pkg::onehot(second_index);
		nxt.md2      = dews_pkg::onehot(fourth_index);
		nxt.bm1      = dews_pkg::between_mask(src_first, dst1);
		nxt.bm2      = dews_pkg::between_mask(second_index, fourth_index);
	end

	assign ready_o = !valid_s1 || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_o) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_i && ready_o) begin
			data_s1 <= nxt;
		end
	end

endmodule

### rtl/dews_move.sv
// ---------------------------------------------------------------------------
// dews_move
// Stage 2: occupancy checks, applies both moves, masks parity operands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dews_move (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_i,
	output logic           ready_o,
	input  dews_pkg::dec_t data_i,
	output logic           valid_s2,
	input  logic           ready_i,
	output dews_pkg::mov_t data_s2
);

	dews_pkg::mov_t nxt;
	dews_pkg::occ_t occ1;
	dews_pkg::occ_t occ2;
	dews_pkg::occ_t new1;
	dews_pkg::occ_t str2_in;
	dews_pkg::occ_t str2_out;
	dews_pkg::occ_t final1;
	logic           ok1;
	logic           ok2;

	always_comb begin
		occ1 = data_i.on_down ? data_i.dn : data_i.up;
		occ2 = data_i.is_ud ? data_i.dn : occ1;
		ok1  = ((occ1 & data_i.ms1) != '0) && ((occ1 & data_i.md1) == '0);
		// second move checked on the original string
		ok2  = ((occ2 & data_i.ms2) != '0) && ((occ2 & data_i.md2) == '0);
		new1 = (occ1 ^ data_i.ms1) | data_i.md1;
		// same-spin double: second move acts on the once-moved string
		str2_in  = data_i.is_ud ? data_i.dn : new1;
		str2_out = (str2_in ^ data_i.ms2) | data_i.md2;
		final1   = (data_i.is_double && !data_i.is_ud) ? str2_out : new1;

		nxt.nu = data_i.on_down ? data_i.up : final1;
		nxt.nd = data_i.is_ud ? str2_out : (data_i.on_down ? final1 : data_i.dn);
		nxt.ok = data_i.kind_ok && ok1 &&
			(!data_i.is_double || (ok2 && (data_i.is_ud || data_i.distinct)));
		nxt.v1 = occ1 & data_i.bm1;
		nxt.v2 = data_i.is_double ? (str2_in & data_i.bm2) : '0;
	end

	assign ready_o = !valid_s2 || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_o) begin
			valid_s2 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_i && ready_o) begin
			data_s2 <= nxt;
		end
	end

endmodule

### rtl/dews_sign.sv
// ---------------------------------------------------------------------------
// dews_sign
// Stage 3: parity reduction, zeroing of rejected items, output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dews_sign (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_i,
	output logic           ready_o,
	input  dews_pkg::mov_t data_i,
	output logic           valid_s3,
	input  logic           ready_i,
	output dews_pkg::occ_t nu_s3,
	output dews_pkg::occ_t nd_s3,
	output logic           ok_s3,
	output logic           neg_s3
);

	assign ready_o = !valid_s3 || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_o) begin
			valid_s3 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_i && ready_o) begin
			nu_s3  <= data_i.ok ? data_i.nu : '0;
			nd_s3  <= data_i.ok ? data_i.nd : '0;
			ok_s3  <= data_i.ok;
			neg_s3 <= data_i.ok && ((^data_i.v1) ^ (^data_i.v2));
		end
	end

endmodule

### rtl/determinant_excitation_with_sign.sv
// Result path: three register stages (decode, move, sign) from input accept to result valid.
// Throughput: one item per cycle while out_ready is high; each stage holds one item and takes a new
// one whenever it is empty or its item moves on in the same cycle.
// Reset: arst_n clears all stage valid bits asynchronously; payload
// registers are not reset.
// ---------------------------------------------------------------------------
// determinant_excitation_with_sign
// Applies a single or double fermionic excitation to an up/down occupation
// pair, checks occupancy and returns the new strings and the sign.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module determinant_excitation_with_sign (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] up_string,
	input  logic [63:0] down_string,
	input  logic [2:0]  kind,
	input  logic [5:0]  src_first,
	input  logic [5:0]  second_index,
	input  logic [5:0]  third_index,
	input  logic [5:0]  fourth_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] new_up_string,
	output logic [63:0] new_down_string,
	output logic        valid_res,
	output logic        negative
);

	// Stage 1 decodes the kind into move roles: move 1 runs on the up
	// string unless the kind is single down or double down-down; move 2 runs
	// on the down string for up-down doubles and on the same string
	// otherwise. One-hot and between masks are built here.
	// Stage 2 checks occupancy and applies the moves; stage 3 reduces the
	// two masked vectors to the sign and zeroes rejected items.

	logic           v1;
	logic           r1;
	logic           v2;
	logic           r2;
	dews_pkg::dec_t d1;
	dews_pkg::mov_t d2;

	dews_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_i      (in_valid),
		.ready_o      (in_ready),
		.up_string    (up_string),
		.down_string  (down_string),
		.kind         (kind),
		.src_first    (src_first),
		.second_index (second_index),
		.third_index  (third_index),
		.fourth_index (fourth_index),
		.valid_s1     (v1),
		.ready_i      (r1),
		.data_s1      (d1)
	);

	dews_move u_move (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_i  (v1),
		.ready_o  (r1),
		.data_i   (d1),
		.valid_s2 (v2),
		.ready_i  (r2),
		.data_s2  (d2)
	);

	dews_sign u_sign (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_i  (v2),
		.ready_o  (r2),
		.data_i   (d2),
		.valid_s3 (out_valid),
		.ready_i  (out_ready),
		.nu_s3    (new_up_string),
		.nd_s3    (new_down_string),
		.ok_s3    (valid_res),
		.neg_s3   (negative)
	);

	// Items in flight, for checking only.
	logic [1:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(in_valid && in_ready)
				- 2'(out_valid && out_ready);
		end
	end

	a_inflight_count : assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 2'($countones({out_valid, v2, v1})))
		else $error("in-flight count disagrees with stage valid bits");

	a_empty_no_out : assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == 2'd0) |-> !out_valid)
		else $error("result without an item in flight");

	a_neg_needs_valid : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && negative) |-> valid_res)
		else $error("minus sign on a rejected excitation");

	a_reject_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |-> (new_up_string == '0 && new_down_string == '0))
		else $error("rejected excitation carries nonzero strings");

endmodule

### tb/tb_determinant_excitation_with_sign.sv
// ---------------------------------------------------------------------------
// tb_determinant_excitation_with_sign
// Drives excitation items into determinant_excitation_with_sign with random
// idling on both sides. Every accepted result is compared field by field with
// the excited strings, validity and fermionic sign that a typed row carries or the in-bench predictor gives.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_determinant_excitation_with_sign;

	localparam int unsigned RUN_ITEMS  = 1400;
	localparam int unsigned LIMIT      = 500000;  // cycles, far above the slowest run
	localparam int unsigned DRAIN      = 10;      // pipeline is 3 deep

	typedef logic [dews_pkg::KINDW-1:0] kind_t;

	// kind codes that the block must reject
	localparam kind_t KIND_RSV_A = 3'd5;
	localparam kind_t KIND_RSV_B = 3'd6;
	localparam kind_t KIND_RSV_C = 3'd7;

	localparam dews_pkg::occ_t ALL_ONES = '1;
	localparam dews_pkg::occ_t TOP_BIT  = 64'h8000_0000_0000_0000;

	localparam logic TYPED     = 1'b1;  // row carries its own expected result
	localparam logic PREDICTED = 1'b0;  // row is checked against the predictor

	// one input item, fields named after the ports
	typedef struct packed {
		dews_pkg::occ_t up;
		dews_pkg::occ_t dn;
		kind_t          kind;
		dews_pkg::idx_t src_first;
		dews_pkg::idx_t second_index;
		dews_pkg::idx_t third_index;
		dews_pkg::idx_t fourth_index;
	} exc_item_t;

	// one result item
	typedef struct packed {
		dews_pkg::occ_t new_up;
		dews_pkg::occ_t new_dn;
		logic           allowed;
		logic           minus;
	} exc_res_t;

	// outcome of one orbital move on one string
	typedef struct packed {
		logic           ok;
		dews_pkg::occ_t occ;
		logic           par;
	} hop_t;

	typedef struct packed {
		exc_item_t item;
		logic      fixed;
		exc_res_t  want;
	} dir_row_t;

	localparam exc_res_t REJECTED = '0;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] up_string;
	logic [63:0] down_string;
	logic [2:0]  kind;
	logic [5:0]  src_first;
	logic [5:0]  second_index;
	logic [5:0]  third_index;
	logic [5:0]  fourth_index;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] new_up_string;
	logic [63:0] new_down_string;
	logic        valid_res;
	logic        negative;

	exc_res_t    excited_q[$];    // expected results, oldest first
	exc_res_t    next_excited;    // expectation for the item now on the inputs
	exc_res_t    head;
	dir_row_t    plan[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	logic        snd_calm = 1'b0; // sender burst phase: no gaps
	logic        rcv_calm = 1'b0; // receiver burst phase: no stalls

	determinant_excitation_with_sign dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.up_string       (up_string),
		.down_string     (down_string),
		.kind            (kind),
		.src_first       (src_first),
		.second_index    (second_index),
		.third_index     (third_index),
		.fourth_index    (fourth_index),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.new_up_string   (new_up_string),
		.new_down_string (new_down_string),
		.valid_res       (valid_res),
		.negative        (negative)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// parity of the occupied orbitals strictly between p and q
	function automatic logic span_parity(input dews_pkg::occ_t occ,
			input dews_pkg::idx_t p, input dews_pkg::idx_t q);
		dews_pkg::idx_t lo;
		dews_pkg::idx_t hi;
		logic par;
		lo  = (p < q) ? p : q;
		hi  = (p < q) ? q : p;
		par = 1'b0;
		for (int k = 0; k < dews_pkg::NORB; k++) begin
			if (k > lo && k < hi)
				par ^= occ[k];
		end
		return par;
	endfunction

	// move one electron s -> d; needs s occupied and d empty
	function automatic hop_t hop(input dews_pkg::occ_t occ, input dews_pkg::idx_t s,
			input dews_pkg::idx_t d);
		hop_t m;
		m.ok  = 1'b0;
		m.occ = occ;
		m.par = 1'b0;
		if (occ[s] && !occ[d]) begin
			m.ok     = 1'b1;
			m.occ[s] = 1'b0;
			m.occ[d] = 1'b1;
			m.par    = span_parity(occ, s, d);
		end
		return m;
	endfunction

	// same-spin double: i -> a, then j -> b counted on the once-moved string
	function automatic hop_t hop_pair(input dews_pkg::occ_t occ, input dews_pkg::idx_t i,
			input dews_pkg::idx_t j, input dews_pkg::idx_t a, input dews_pkg::idx_t b);
		hop_t           m;
		dews_pkg::occ_t mid;
		m.ok  = 1'b0;
		m.occ = occ;
		m.par = 1'b0;
		if (i != j && a != b && occ[i] && occ[j] && !occ[a] && !occ[b]) begin
			mid    = occ;
			mid[i] = 1'b0;
			mid[a] = 1'b1;
			m.occ  = mid;
			m.occ[j] = 1'b0;
			m.occ[b] = 1'b1;
			m.ok   = 1'b1;
			m.par  = span_parity(occ, i, a) ^ span_parity(mid, j, b);
		end
		return m;
	endfunction

	function automatic exc_res_t excite(input exc_item_t it);
		hop_t           m1;
		hop_t           m2;
		exc_res_t       r;
		dews_pkg::occ_t nu;
		dews_pkg::occ_t nd;
		logic           ok;
		logic           par;
		nu  = it.up;
		nd  = it.dn;
		ok  = 1'b0;
		par = 1'b0;
		case (it.kind)
			dews_pkg::KIND_SINGLE_UP: begin
				m1 = hop(it.up, it.src_first, it.second_index);
				{ok, nu, par} = {m1.ok, m1.occ, m1.par};
			end
			dews_pkg::KIND_SINGLE_DOWN: begin
				m1 = hop(it.dn, it.src_first, it.second_index);
				{ok, nd, par} = {m1.ok, m1.occ, m1.par};
			end
			dews_pkg::KIND_DOUBLE_UU: begin
				m1 = hop_pair(it.up, it.src_first, it.second_index,
					it.third_index, it.fourth_index);
				{ok, nu, par} = {m1.ok, m1.occ, m1.par};
			end
			dews_pkg::KIND_DOUBLE_DD: begin
				m1 = hop_pair(it.dn, it.src_first, it.second_index,
					it.third_index, it.fourth_index);
				{ok, nd, par} = {m1.ok, m1.occ, m1.par};
			end
			dews_pkg::KIND_DOUBLE_UD: begin
				// up moves src_first -> third_index, down moves second -> fourth
				m1  = hop(it.up, it.src_first, it.third_index);
				m2  = hop(it.dn, it.second_index, it.fourth_index);
				ok  = m1.ok && m2.ok;
				nu  = m1.occ;
				nd  = m2.occ;
				par = m1.par ^ m2.par;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		r = REJECTED;
		if (ok) begin
			r.new_up  = nu;
			r.new_dn  = nd;
			r.allowed = 1'b1;
			r.minus   = par;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic exc_item_t pack_item(input dews_pkg::occ_t up,
			input dews_pkg::occ_t dn, input kind_t k, input dews_pkg::idx_t s,
			input dews_pkg::idx_t t2, input dews_pkg::idx_t t3, input dews_pkg::idx_t t4);
		exc_item_t it;
		it.up           = up;
		it.dn           = dn;
		it.kind         = k;
		it.src_first    = s;
		it.second_index = t2;
		it.third_index  = t3;
		it.fourth_index = t4;
		return it;
	endfunction

	function automatic exc_res_t outcome(input dews_pkg::occ_t nu, input dews_pkg::occ_t nd,
			input logic ok, input logic neg);
		exc_res_t r;
		r.new_up  = nu;
		r.new_dn  = nd;
		r.allowed = ok;
		r.minus   = neg;
		return r;
	endfunction

	task automatic add_row(input exc_item_t it, input logic fixed, input exc_res_t want);
		dir_row_t r;
		r.item  = it;
		r.fixed = fixed;
		r.want  = want;
		plan.insert(plan.size(), r);
	endtask

	function automatic dews_pkg::occ_t rnd64();
		return {$urandom, $urandom};
	endfunction

	// random string of varying density
	function automatic dews_pkg::occ_t shade();
		case ($urandom_range(0, 2))
			0:       return rnd64() & rnd64();
			1:       return rnd64() | rnd64();
			default: return rnd64();
		endcase
	endfunction

	// Mostly well-formed excitations with random content; the rest is raw
	// noise (any kind) or a legal move broken on purpose.
	function automatic exc_item_t gen_item();
		exc_item_t      it;
		dews_pkg::idx_t base;
		dews_pkg::idx_t stride;
		dews_pkg::occ_t w;
		logic           on_dn;
		logic           single;
		it.up           = shade();
		it.dn           = shade();
		it.kind         = kind_t'($urandom_range(0, 7));
		it.src_first    = dews_pkg::idx_t'($urandom_range(0, 63));
		it.second_index = dews_pkg::idx_t'($urandom_range(0, 63));
		it.third_index  = dews_pkg::idx_t'($urandom_range(0, 63));
		it.fourth_index = dews_pkg::idx_t'($urandom_range(0, 63));
		if ($urandom_range(0, 99) < 20)
			return it;

		it.kind = kind_t'($urandom_range(dews_pkg::KIND_SINGLE_UP, dews_pkg::KIND_DOUBLE_DD));
		// odd stride keeps four steps from the base distinct mod 64
		base   = dews_pkg::idx_t'($urandom_range(0, 63));
		stride = dews_pkg::idx_t'(2 * $urandom_range(0, 31) + 1);
		single = (it.kind == dews_pkg::KIND_SINGLE_UP) ||
			(it.kind == dews_pkg::KIND_SINGLE_DOWN);
		on_dn  = (it.kind == dews_pkg::KIND_SINGLE_DOWN) ||
			(it.kind == dews_pkg::KIND_DOUBLE_DD);
		it.src_first = base;
		if (it.kind == dews_pkg::KIND_DOUBLE_UD) begin
			it.third_index  = base + stride;
			stride          = dews_pkg::idx_t'(2 * $urandom_range(0, 31) + 1);
			it.fourth_index = it.second_index + stride;
			it.up[it.src_first]    = 1'b1;
			it.up[it.third_index]  = 1'b0;
			it.dn[it.second_index] = 1'b1;
			it.dn[it.fourth_index] = 1'b0;
		end else begin
			it.second_index = base + stride;
			w = on_dn ? it.dn : it.up;
			w[it.src_first] = 1'b1;
			if (single) begin
				w[it.second_index] = 1'b0;
			end else begin
				it.third_index  = base + dews_pkg::idx_t'(2 * stride);
				it.fourth_index = base + dews_pkg::idx_t'(3 * stride);
				w[it.second_index] = 1'b1;
				w[it.third_index]  = 1'b0;
				w[it.fourth_index] = 1'b0;
			end
			if (on_dn)
				it.dn = w;
			else
				it.up = w;
		end

		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 2))
				0: begin
					// vacate the first source
					if (on_dn)
						it.dn[it.src_first] = 1'b0;
					else
						it.up[it.src_first] = 1'b0;
				end
				1:       it.second_index = it.src_first;
				default: it.fourth_index = it.third_index;
			endcase
		end
		return it;
	endfunction

	// put one item on the inputs and hold it until accepted
	task automatic send(input exc_item_t it, input logic fixed, input exc_res_t want);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			snd_calm = !snd_calm;
		gap = snd_calm ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		up_string    = it.up;
		down_string  = it.dn;
		kind         = it.kind;
		src_first    = it.src_first;
		second_index = it.second_index;
		third_index  = it.third_index;
		fourth_index = it.fourth_index;
		next_excited = fixed ? want : excite(it);
		in_valid     = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// hold off the sender until every expected result is back
	task automatic wait_drained();
		if (excited_q.size() != 0) begin
			in_valid = 1'b0;
			while (excited_q.size() != 0)
				@(negedge clk);
		end
	endtask

	task automatic compare(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t %s: expected %h, got %h", $time, what, want, got);
		end
	endtask

	// ---------------------------------------------------------------------
	// Scoreboard: record accepted items first, then check the result, so a
	// same-edge result still finds its expectation.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				excited_q.insert(excited_q.size(), next_excited);
			if (out_valid && out_ready) begin
				if (excited_q.size() == 0) begin
					errors++;
					$display("%0t unexpected item: expected none, got %h %h %b %b",
						$time, new_up_string, new_down_string, valid_res, negative);
				end else begin
					head = excited_q.pop_front();
					compare("new_up_string", head.new_up, new_up_string);
					compare("new_down_string", head.new_dn, new_down_string);
					compare("valid_res", 64'(head.allowed), 64'(valid_res));
					compare("negative", 64'(head.minus), 64'(negative));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb_determinant_excitation_with_sign: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: random stall before each result, with bursts of none
	// ---------------------------------------------------------------------
	initial begin : receiver
		int unsigned stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rcv_calm = !rcv_calm;
			stall = rcv_calm ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// ---------------------------------------------------------------------
	// Sender: directed table, drain, random items with a drain halfway, drain, verdict
	// ---------------------------------------------------------------------
	initial begin : sender
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		up_string    = '0;
		down_string  = '0;
		kind         = dews_pkg::KIND_SINGLE_UP;
		src_first    = '0;
		second_index = '0;
		third_index  = '0;
		fourth_index = '0;
		next_excited = REJECTED;

		// singles: extremes of index and string, sign across the whole word
		add_row(pack_item(64'h1, ALL_ONES, dews_pkg::KIND_SINGLE_UP, 6'd0, 6'd63, 6'd0, 6'd0),
			TYPED, outcome(TOP_BIT, ALL_ONES, 1'b1, 1'b0));
		add_row(pack_item('0, TOP_BIT, dews_pkg::KIND_SINGLE_DOWN, 6'd63, 6'd0, 6'd63, 6'd63),
			TYPED, outcome('0, 64'h1, 1'b1, 1'b0));
		add_row(pack_item(ALL_ONES, '0, dews_pkg::KIND_SINGLE_UP, 6'd0, 6'd63, 6'd0, 6'd0),
			TYPED, REJECTED);
		add_row(pack_item(~TOP_BIT, '0, dews_pkg::KIND_SINGLE_UP, 6'd0, 6'd63, 6'd0, 6'd0),
			PREDICTED, REJECTED);
		// unused indices carry junk
		add_row(pack_item(ALL_ONES, 64'h3, dews_pkg::KIND_SINGLE_DOWN,
			6'd0, 6'd63, 6'd17, 6'd42), PREDICTED, REJECTED);
		// source equals target, then an empty source
		add_row(pack_item(ALL_ONES, ALL_ONES, dews_pkg::KIND_SINGLE_UP,
			6'd7, 6'd7, 6'd0, 6'd0), TYPED, REJECTED);
		add_row(pack_item('0, '0, dews_pkg::KIND_SINGLE_DOWN, 6'd0, 6'd1, 6'd0, 6'd0),
			TYPED, REJECTED);
		// adjacent positions: nothing in between
		add_row(pack_item(64'hF0F0_F0F0_F0F0_F0A0, 64'h1234_5678_9ABC_DEF0,
			dews_pkg::KIND_SINGLE_UP, 6'd5, 6'd6, 6'd63, 6'd63), PREDICTED, REJECTED);

		// unknown kinds, one of them on a move that would otherwise pass
		add_row(pack_item(64'h1, 64'h1, KIND_RSV_A, 6'd0, 6'd1, 6'd2, 6'd3),
			TYPED, REJECTED);
		add_row(pack_item(ALL_ONES, ALL_ONES, KIND_RSV_B, 6'd63, 6'd0, 6'd63, 6'd0),
			TYPED, REJECTED);
		add_row(pack_item(ALL_ONES, ALL_ONES, KIND_RSV_C, 6'd63, 6'd63, 6'd63, 6'd63),
			TYPED, REJECTED);

		// up-up doubles: legal, repeated source, repeated target, and a second
		// move that crosses the first target
		add_row(pack_item(64'hFF, '0, dews_pkg::KIND_DOUBLE_UU, 6'd0, 6'd7, 6'd63, 6'd8),
			PREDICTED, REJECTED);
		add_row(pack_item(64'hFF, '0, dews_pkg::KIND_DOUBLE_UU, 6'd3, 6'd3, 6'd40, 6'd41),
			TYPED, REJECTED);
		add_row(pack_item(64'hFF, '0, dews_pkg::KIND_DOUBLE_UU, 6'd1, 6'd2, 6'd40, 6'd40),
			TYPED, REJECTED);
		add_row(pack_item(64'h0F, ALL_ONES, dews_pkg::KIND_DOUBLE_UU,
			6'd0, 6'd3, 6'd10, 6'd20), PREDICTED, REJECTED);

		// down-down doubles
		add_row(pack_item(ALL_ONES, 64'hAAAA_AAAA_AAAA_AAAA, dews_pkg::KIND_DOUBLE_DD,
			6'd63, 6'd1, 6'd0, 6'd62), PREDICTED, REJECTED);
		add_row(pack_item(ALL_ONES, 64'hAAAA_AAAA_AAAA_AAAA, dews_pkg::KIND_DOUBLE_DD,
			6'd63, 6'd1, 6'd3, 6'd0), TYPED, REJECTED);
		add_row(pack_item('0, 64'hAAAA_AAAA_AAAA_AAAA, dews_pkg::KIND_DOUBLE_DD,
			6'd5, 6'd5, 6'd0, 6'd2), TYPED, REJECTED);

		// up-down doubles: legal, up side fails, down side fails, dense strings
		add_row(pack_item(TOP_BIT, 64'h1, dews_pkg::KIND_DOUBLE_UD, 6'd63, 6'd0, 6'd0, 6'd63),
			PREDICTED, REJECTED);
		add_row(pack_item(TOP_BIT, 64'h1, dews_pkg::KIND_DOUBLE_UD, 6'd62, 6'd0, 6'd0, 6'd63),
			TYPED, REJECTED);
		add_row(pack_item(TOP_BIT, 64'h1, dews_pkg::KIND_DOUBLE_UD, 6'd63, 6'd0, 6'd0, 6'd0),
			TYPED, REJECTED);
		add_row(pack_item(64'h5555_5555_5555_5555, 64'h3333_3333_3333_3333,
			dews_pkg::KIND_DOUBLE_UD, 6'd0, 6'd0, 6'd1, 6'd2), PREDICTED, REJECTED);

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[n])
			send(plan[n].item, plan[n].fixed, plan[n].want);
		wait_drained();

		for (int n = 0; n < RUN_ITEMS; n++) begin
			if (n == RUN_ITEMS / 2)
				wait_drained();
			send(gen_item(), PREDICTED, REJECTED);
		end
		in_valid = 1'b0;
		wait_drained();
		repeat (DRAIN) @(negedge clk);

		if (errors == 0)
			$display("tb_determinant_excitation_with_sign: clean");
		else
			$display("tb_determinant_excitation_with_sign: errors");
		$finish;
	end

endmodule
